/* rtl/mvsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared constants, register indexes and word types of the stereo voice mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

    localparam int MAX_VOICES         = 4;
    localparam int DEF_VOICE_COUNT    = 4;
    localparam int DEF_POSITION_BITS  = 24;
    localparam int DEF_QUEUE_DEPTH    = 4;

    localparam int VOICE_W    = 2;
    localparam int SAMPLE_W   = 16;
    localparam int VOLUME_W   = 8;
    localparam int LENGTH_W   = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_VOLUMES   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PLAY_MASK = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LENGTH0   = 3'd2;

    // classified item handed from front to back
    typedef struct packed {
        logic                       hit;
        logic [VOLUME_W-1:0]        vol;
        logic signed [SAMPLE_W-1:0] lsample;
        logic signed [SAMPLE_W-1:0] rsample;
        logic                       last;
    } mvsm_word_t;

    // finished frame
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lmix;
        logic signed [SAMPLE_W-1:0] rmix;
        logic                       active;
    } mvsm_result_t;

endpackage

/* rtl/multi_voice_saturating_mixer_top.sv */
`timescale 1ns / 1ps
// frame_end to empty: registered in the word queue, stages a and b, result queue
// throughput: one word per cycle unless a frame waits on a full result queue; the
// multiply, divide-by-255 and clamp stages each take a word every cycle
// reset: asynchronous, clears volumes, play mask, lengths, positions, sums and queues
// ----------------------------------------------------------------------------
// multi_voice_saturating_mixer_top
// Four-voice stereo 16-bit mixer with per-voice volume and saturating sums.
// ----------------------------------------------------------------------------
module multi_voice_saturating_mixer_top
    import mvsm_pkg::*;
#(
    parameter int VOICE_COUNT   = DEF_VOICE_COUNT,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       push,
    output logic                       full,
    input  logic [VOICE_W-1:0]         voice,
    input  logic signed [SAMPLE_W-1:0] left_in,
    input  logic signed [SAMPLE_W-1:0] right_in,
    input  logic                       frame_end,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out,
    output logic                       any_active
);

    mvsm_word_t   in_word, q_word;
    mvsm_result_t res_in, res_out;
    logic         accept;
    logic         q_empty, q_pop;
    logic         res_push, res_full;

    assign accept = push && !full;

    mvsm_front #(
        .VOICE_COUNT   (VOICE_COUNT),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .voice     (voice),
        .left_in   (left_in),
        .right_in  (right_in),
        .frame_end (frame_end),
        .word      (in_word)
    );

    mvsm_fifo #(
        .WIDTH ($bits(mvsm_word_t)),
        .DEPTH (DEF_QUEUE_DEPTH)
    ) u_word_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_word),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_word),
        .empty (q_empty)
    );

    mvsm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .word        (q_word),
        .word_empty  (q_empty),
        .word_pop    (q_pop),
        .result      (res_in),
        .result_push (res_push),
        .result_full (res_full)
    );

    mvsm_fifo #(
        .WIDTH ($bits(mvsm_result_t)),
        .DEPTH (DEF_QUEUE_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign left_out   = res_out.lmix;
    assign right_out  = res_out.rmix;
    assign any_active = res_out.active;

endmodule

/* rtl/mvsm_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_fifo
// Small first-in first-out queue with registered storage and occupancy count.
// ----------------------------------------------------------------------------
module mvsm_fifo
    import mvsm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/mvsm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_front
// Holds configuration and play positions, decides per word whether the voice
// contributes and advances its position.
// ----------------------------------------------------------------------------
module mvsm_front
    import mvsm_pkg::*;
#(
    parameter int VOICE_COUNT   = DEF_VOICE_COUNT,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       accept,
    input  logic [VOICE_W-1:0]         voice,
    input  logic signed [SAMPLE_W-1:0] left_in,
    input  logic signed [SAMPLE_W-1:0] right_in,
    input  logic                       frame_end,
    output mvsm_word_t                 word
);

    localparam int CMP_W = (POSITION_BITS > LENGTH_W) ? POSITION_BITS : LENGTH_W;

    logic [MAX_VOICES*VOLUME_W-1:0] volumes_reg;
    logic [MAX_VOICES-1:0]          mask_reg;
    logic [LENGTH_W-1:0]            length_reg [VOICE_COUNT];
    logic [POSITION_BITS-1:0]       pos_reg    [VOICE_COUNT];
    logic [VOICE_COUNT-1:0]         hit_vec;
    logic [VOLUME_W-1:0]            vol_sel;

    always_comb
    begin
        vol_sel = '0;
        for (int v = 0; v < VOICE_COUNT; v++)
        begin
            hit_vec[v] = (voice == VOICE_W'(v)) && mask_reg[v]
                         && (CMP_W'(pos_reg[v]) < CMP_W'(length_reg[v]));
            if (voice == VOICE_W'(v))
            begin
                vol_sel = volumes_reg[v*VOLUME_W +: VOLUME_W];
            end
        end
    end

    always_comb
    begin
        word.hit     = |hit_vec;
        word.vol     = vol_sel;
        word.lsample = left_in;
        word.rsample = right_in;
        word.last    = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volumes_reg <= '0;
            mask_reg    <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_VOLUMES)
            begin
                volumes_reg <= cfg_wdata[MAX_VOICES*VOLUME_W-1:0];
            end
            if (cfg_addr == REG_PLAY_MASK)
            begin
                mask_reg <= cfg_wdata[MAX_VOICES-1:0];
            end
        end
    end

    // a length write rewinds the voice; otherwise an accepted hit advances it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                length_reg[v] <= '0;
                pos_reg[v]    <= '0;
            end
        end
        else
        begin
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                if (cfg_we && (cfg_addr == REG_LENGTH0 + CFG_ADDR_W'(v)))
                begin
                    length_reg[v] <= cfg_wdata[LENGTH_W-1:0];
                    pos_reg[v]    <= '0;
                end
                else if (accept && hit_vec[v])
                begin
                    pos_reg[v] <= pos_reg[v] + 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/mvsm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_back
// Scales samples by volume/255, accumulates with saturation and emits frames.
// Stages: multiply, divide by 255, accumulate and clamp.
// ----------------------------------------------------------------------------
module mvsm_back
    import mvsm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  mvsm_word_t   word,
    input  logic         word_empty,
    output logic         word_pop,
    output mvsm_result_t result,
    output logic         result_push,
    input  logic         result_full
);

    localparam int PROD_W = SAMPLE_W + VOLUME_W + 1;
    localparam int MAG_W  = PROD_W - 1;
    localparam int CONT_W = SAMPLE_W + 1;
    localparam int ACC_W  = SAMPLE_W + 2;

    // |p| / 255 via (m * 257) >> 16, which is low by at most one, then one fixup
    function automatic logic signed [CONT_W-1:0] div255(input logic signed [PROD_W-1:0] p);
        logic [MAG_W-1:0]    mag;
        logic [31:0]         t;
        logic [15:0]         q0;
        logic [PROD_W-1:0]   rem;
        logic [CONT_W-1:0]   q;
        mag = p[PROD_W-1] ? MAG_W'(-p) : MAG_W'(p);
        t   = 32'(mag) + {mag, 8'b0};
        q0  = t[31:16];
        rem = PROD_W'(mag) + PROD_W'(q0) - {1'b0, q0, 8'b0};
        q   = CONT_W'(q0) + ((rem >= PROD_W'(255)) ? CONT_W'(1) : CONT_W'(0));
        return p[PROD_W-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] x);
        if (x < -ACC_W'(32768))
        begin
            return SAMPLE_W'(-32768);
        end
        else if (x > ACC_W'(32767))
        begin
            return SAMPLE_W'(32767);
        end
        return x[SAMPLE_W-1:0];
    endfunction

    logic                     stall;
    logic                     a_valid_reg, a_hit_reg, a_last_reg;
    logic signed [PROD_W-1:0] a_lprod_reg, a_rprod_reg;
    logic                     b_valid_reg, b_hit_reg, b_last_reg;
    logic signed [CONT_W-1:0] b_lc_reg, b_rc_reg;
    logic signed [SAMPLE_W-1:0] lsum_reg, lsum_next, rsum_reg, rsum_next;
    logic                     active_reg, active_next;
    logic signed [SAMPLE_W-1:0] lsum_add, rsum_add;
    logic                     active_add;
    logic signed [PROD_W-1:0] lprod, rprod;

    assign stall    = b_valid_reg && b_last_reg && result_full;
    assign word_pop = !word_empty && !stall;

    assign lprod = PROD_W'(word.lsample) * $signed({1'b0, word.vol});
    assign rprod = PROD_W'(word.rsample) * $signed({1'b0, word.vol});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            a_valid_reg <= word_pop;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            a_hit_reg   <= word.hit;
            a_last_reg  <= word.last;
            a_lprod_reg <= lprod;
            a_rprod_reg <= rprod;
            b_hit_reg   <= a_hit_reg;
            b_last_reg  <= a_last_reg;
            b_lc_reg    <= div255(a_lprod_reg);
            b_rc_reg    <= div255(a_rprod_reg);
        end
    end

    always_comb
    begin
        lsum_add    = lsum_reg;
        rsum_add    = rsum_reg;
        active_add  = active_reg;
        if (b_hit_reg)
        begin
            lsum_add   = sat16(ACC_W'(lsum_reg) + ACC_W'(b_lc_reg));
            rsum_add   = sat16(ACC_W'(rsum_reg) + ACC_W'(b_rc_reg));
            active_add = 1'b1;
        end
        lsum_next   = lsum_reg;
        rsum_next   = rsum_reg;
        active_next = active_reg;
        if (b_valid_reg && !stall)
        begin
            lsum_next   = b_last_reg ? '0 : lsum_add;
            rsum_next   = b_last_reg ? '0 : rsum_add;
            active_next = b_last_reg ? 1'b0 : active_add;
        end
        result_push   = b_valid_reg && b_last_reg && !result_full;
        result.lmix   = lsum_add;
        result.rmix   = rsum_add;
        result.active = active_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsum_reg   <= '0;
            rsum_reg   <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            lsum_reg   <= lsum_next;
            rsum_reg   <= rsum_next;
            active_reg <= active_next;
        end
    end

endmodule
